// ----- rtl/hptm_pkg.sv -----
// Package for the HDR pixel tone map and pack core: pipeline sizes and the
// per-channel float32 conversion and divider step functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hptm_pkg;

  localparam int NUM_STAGES = 12;
  localparam int DIV_STAGES = 8;
  localparam int FIRST_DIV = 2;
  localparam int MUL_STAGE = FIRST_DIV + DIV_STAGES;
  localparam int ROM_STAGE = MUL_STAGE + 1;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  function automatic logic [31:0] to_fixed(input logic [31:0] f);
    logic [7:0] e;
    logic [23:0] sig;
    logic [31:0] r;
    e = f[30:23];
    sig = {(e != 8'd0), f[22:0]};
    if (e == 8'd0) e = 8'd1;
    if (f[31]) begin
      r = '0;
    end else if (f[30:23] == 8'hFF) begin
      r = (f[22:0] != 23'd0) ? 32'd0 : 32'hFFFF_FFFF;
    end else if (e >= 8'd134) begin
      if ((e - 8'd134) > 8'd8) r = 32'hFFFF_FFFF;
      else r = {8'd0, sig} << (e - 8'd134);
    end else if ((8'd134 - e) >= 8'd32) begin
      r = '0;
    end else begin
      r = {8'd0, sig} >> (8'd134 - e);
    end
    return r;
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic s;
    logic [7:0] e;
    logic [22:0] m;
    logic [14:0] r;
    logic [31:0] sig;
    logic [31:0] hm;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0] sh;
    s = f[31];
    e = f[30:23];
    m = f[22:0];
    r = '0;
    sig = {8'd0, 1'b1, m};
    sh = 8'd126 - e;
    hm = '0;
    rem = '0;
    half = '0;
    if (e == 8'hFF) begin
      r = (m != 23'd0) ? {5'h1F, 1'b1, m[21:13]} : 15'h7C00;
    end else if (e == 8'd0) begin
      r = '0;
    end else if (e > 8'd142) begin
      r = 15'h7C00;
    end else if (e >= 8'd113) begin
      r = {e[4:0] - 5'd16, m[22:13]};
      if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && m[13])) r = r + 15'd1;
    end else if (sh <= 8'd25) begin
      hm = sig >> sh;
      rem = sig & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 8'd1);
      if (rem > half || (rem == half && hm[0])) hm = hm + 32'd1;
      r = hm[14:0];
    end
    return {s, r};
  endfunction

  // One restoring step of the divider: quotient bit on top, new remainder below.
  function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [32:0] d);
    logic [33:0] sh;
    logic [33:0] res;
    sh = {rem, 1'b0};
    if (sh >= {1'b0, d}) begin
      res = {1'b1, 33'(sh - {1'b0, d})};
    end else begin
      res = {1'b0, sh[32:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hptm_lane.sv -----
// One colour lane of the tone mapper: fixed point, pipelined x/(1+x) divider,
// table index multiply and gamma ROM read. Depends on hptm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hptm_lane #(
  parameter int DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire hptm_pkg::stage_en_t en,
  input  wire logic [31:0]        f,
  output logic [7:0]              value
);
  import hptm_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  localparam int PW = 16 + DW;

  function automatic logic [DEPTH*8-1:0] build_rom();
    logic [DEPTH*8-1:0] rom;
    logic [159:0] rhs;
    logic [159:0] lhs;
    int lo;
    int hi;
    int mid;
    rom = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rhs = 160'd1;
      for (int k = 0; k < 11; k++) rhs = rhs * 160'd255;
      for (int k = 0; k < 5; k++) rhs = rhs * 160'(i);
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 160'd1;
        for (int k = 0; k < 11; k++) lhs = lhs * 160'(mid);
        for (int k = 0; k < 5; k++) lhs = lhs * 160'(DEPTH);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      rom[i*8 +: 8] = 8'(lo);
    end
    return rom;
  endfunction

  localparam logic [DEPTH*8-1:0] GammaRom = build_rom();

  logic [32:0] rem [0:DIV_STAGES];
  logic [32:0] dvs [0:DIV_STAGES];
  logic [15:0] quo [0:DIV_STAGES];
  logic [IW-1:0] idx;
  logic [PW-1:0] prod;
  logic [31:0] fx;

  assign fx = to_fixed(f);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0] <= {1'b0, fx};
      dvs[0] <= {1'b0, fx} + 33'h1_0000;
      quo[0] <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [33:0] s1;
    logic [33:0] s2;
    assign s1 = div_step(rem[j], dvs[j]);
    assign s2 = div_step(s1[32:0], dvs[j]);
    always_ff @(posedge clk) begin
      if (en[FIRST_DIV + j]) begin
        rem[j+1] <= s2[32:0];
        dvs[j+1] <= dvs[j];
        quo[j+1] <= {quo[j][13:0], s1[33], s2[33]};
      end
    end
  end

  assign prod = PW'(quo[DIV_STAGES]) * PW'(DEPTH);

  always_ff @(posedge clk) begin
    if (en[MUL_STAGE]) begin
      idx <= prod[16 +: IW];
    end
    if (en[ROM_STAGE]) begin
      value <= GammaRom[{idx, 3'b000} +: 8];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hdr_pixel_tone_map_pack_core.sv -----
// Top level of the HDR pixel tone map and pack core: handshake, valid
// pipeline, half-float packing and three tone map lanes. Depends on hptm_pkg, hptm_lane.
//
//   channel  direction  signals
//   input    in         in_valid, in_ready, red_in, green_in, blue_in, alpha_in
//   output   out        out_valid, out_ready, red_out, green_out, blue_out, alpha_out
//   config   in         cfg_we, cfg_data (hdr_mode)
//
// One word enters per cycle unless a stalled output has backed the pipeline up to the input.
// The pipeline has twelve register stages: input, fixed-point conversion, the
// eight-stage restoring divider, multiply and ROM read. Each stage advances when the
// one after it is empty or moving, so a stalled output holds only the words behind it.
// Reset clears the valid bits and hdr_mode.
`timescale 1ns / 1ps
`default_nettype none
module hdr_pixel_tone_map_pack_core #(
  parameter int GAMMA_TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] red_in,
  input  wire logic [31:0] green_in,
  input  wire logic [31:0] blue_in,
  input  wire logic [31:0] alpha_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      red_out,
  output logic [15:0]      green_out,
  output logic [15:0]      blue_out,
  output logic [15:0]      alpha_out
);
  import hptm_pkg::*;

  logic hdr_mode;
  stage_en_t en;
  stage_en_t vld;
  logic mode_p [0:NUM_STAGES-1];
  logic [63:0] half_p [1:NUM_STAGES-1];
  logic [31:0] f_r, f_g, f_b, f_a;
  logic [7:0] byte_r, byte_g, byte_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_mode <= 1'b0;
    end else if (cfg_we) begin
      hdr_mode <= cfg_data;
    end
  end

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f_r <= red_in;
      f_g <= green_in;
      f_b <= blue_in;
      f_a <= alpha_in;
      mode_p[0] <= hdr_mode;
    end
    if (en[1]) begin
      half_p[1] <= {to_half(f_r), to_half(f_g), to_half(f_b), to_half(f_a)};
      mode_p[1] <= mode_p[0];
    end
    for (int k = 2; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        half_p[k] <= half_p[k-1];
        mode_p[k] <= mode_p[k-1];
      end
    end
  end

  hptm_lane #(.DEPTH(GAMMA_TABLE_DEPTH)) u_lane_r (.clk(clk), .en(en), .f(f_r), .value(byte_r));
  hptm_lane #(.DEPTH(GAMMA_TABLE_DEPTH)) u_lane_g (.clk(clk), .en(en), .f(f_g), .value(byte_g));
  hptm_lane #(.DEPTH(GAMMA_TABLE_DEPTH)) u_lane_b (.clk(clk), .en(en), .f(f_b), .value(byte_b));

  assign in_ready  = en[0];
  assign out_valid = vld[NUM_STAGES-1];
  assign red_out   = mode_p[NUM_STAGES-1] ? half_p[NUM_STAGES-1][63:48] : {8'd0, byte_r};
  assign green_out = mode_p[NUM_STAGES-1] ? half_p[NUM_STAGES-1][47:32] : {8'd0, byte_g};
  assign blue_out  = mode_p[NUM_STAGES-1] ? half_p[NUM_STAGES-1][31:16] : {8'd0, byte_b};
  assign alpha_out = mode_p[NUM_STAGES-1] ? half_p[NUM_STAGES-1][15:0] : 16'd255;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0]) else $error("accepted word lost at entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("stalled result dropped");

  a_ldr_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mode_p[NUM_STAGES-1] |-> alpha_out == 16'd255 && red_out[15:8] == 8'd0)
    else $error("tone mapped word has wrong format");

endmodule
`default_nettype wire

// ----- tb/sv/tb_hdr_pixel_tone_map_pack_core.sv -----
// Self-checking testbench for hdr_pixel_tone_map_pack_core: drives pixels through
// valid/ready with random idling and checks each output word against a local predictor.
// Depends on the core RTL and hptm_pkg.
`timescale 1ns / 1ps
module tb_hdr_pixel_tone_map_pack_core;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK_SIZE = 255;

  typedef struct packed {
    logic [31:0] r, g, b, a;
    bit          hold;
  } pixel_t;

  typedef struct packed {
    logic [15:0] r, g, b, a;
  } packed_px_t;

  logic        clk, rst;
  logic        cfg_we, cfg_data;
  logic        in_valid, in_ready;
  logic [31:0] red_in, green_in, blue_in, alpha_in;
  logic        out_valid, out_ready;
  logic [15:0] red_out, green_out, blue_out, alpha_out;

  pixel_t     pixel_q[$];
  packed_px_t pending_px_q[$];
  logic [7:0] gamma_lut[DEPTH];
  bit         half_mode;
  bit         in_taken;
  int         send_idle_pct, recv_stall_pct;
  int         mismatches, cycles;

  hdr_pixel_tone_map_pack_core #(.GAMMA_TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .alpha_out(alpha_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void build_gamma_lut();
    logic [191:0] lim, lhs;
    int lo, hi, mid;
    for (int i = 0; i < DEPTH; i++) begin
      lim = 192'd1;
      for (int k = 0; k < 11; k++) lim = lim * 192'd255;
      for (int k = 0; k < 5; k++) lim = lim * 192'(i);
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 192'd1;
        for (int k = 0; k < 11; k++) lhs = lhs * 192'(mid);
        for (int k = 0; k < 5; k++) lhs = lhs * 192'(DEPTH);
        if (lhs <= lim) lo = mid;
        else hi = mid - 1;
      end
      gamma_lut[i] = 8'(lo);
    end
  endfunction

  function automatic logic [31:0] float_to_q16(logic [31:0] f);
    logic [7:0]  ex;
    logic [23:0] mant;
    int          sh;
    ex = f[30:23];
    mant = {ex != 8'd0, f[22:0]};
    if (ex == 8'd0) ex = 8'd1;
    if (f[31]) return 32'd0;
    if (f[30:23] == 8'hFF) return (f[22:0] != 0) ? 32'd0 : 32'hFFFF_FFFF;
    if (ex >= 8'd134) begin
      sh = int'(ex) - 134;
      if (sh > 8) return 32'hFFFF_FFFF;
      return {8'd0, mant} << sh;
    end
    sh = 134 - int'(ex);
    if (sh >= 32) return 32'd0;
    return {8'd0, mant} >> sh;
  endfunction

  function automatic logic [15:0] tone_map_channel(logic [31:0] f);
    logic [63:0] x, frac, idx;
    x = {32'd0, float_to_q16(f)};
    frac = (x << 16) / (x + 64'd65536);
    idx = (frac * DEPTH) >> 16;
    if (idx >= DEPTH) idx = DEPTH - 1;
    return {8'd0, gamma_lut[idx]};
  endfunction

  function automatic logic [15:0] float_to_half(logic [31:0] f);
    logic [15:0] sgn;
    logic [7:0]  ex;
    logic [22:0] mant;
    logic [31:0] sig, q, rest, tie;
    int          unb, sh;
    sgn = {f[31], 15'd0};
    ex = f[30:23];
    mant = f[22:0];
    if (ex == 8'hFF) return (mant != 0) ? (sgn | 16'h7E00 | 16'(mant >> 13)) : (sgn | 16'h7C00);
    if (ex == 8'd0) return sgn;
    unb = int'(ex) - 127;
    if (unb > 15) return sgn | 16'h7C00;
    if (unb >= -14) begin
      q = (32'(unb + 15) << 10) + 32'(mant >> 13);
      rest = 32'(mant[12:0]);
      if (rest > 32'h1000 || (rest == 32'h1000 && q[0])) q = q + 1;
      return sgn | q[15:0];
    end
    sh = -(unb + 1);
    if (sh > 25) return sgn;
    sig = {8'd0, 1'b1, mant};
    q = sig >> sh;
    rest = sig & ((32'd1 << sh) - 1);
    tie = 32'd1 << (sh - 1);
    if (rest > tie || (rest == tie && q[0])) q = q + 1;
    return sgn | q[15:0];
  endfunction

  function automatic packed_px_t predict_pixel(pixel_t p, bit hdr);
    packed_px_t e;
    if (hdr) begin
      e.r = float_to_half(p.r);
      e.g = float_to_half(p.g);
      e.b = float_to_half(p.b);
      e.a = float_to_half(p.a);
    end else begin
      e.r = tone_map_channel(p.r);
      e.g = tone_map_channel(p.g);
      e.b = tone_map_channel(p.b);
      e.a = 16'd255;
    end
    return e;
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0, 1: v[30:23] = 8'($urandom_range(100, 150));
      2: v[30:23] = 8'($urandom_range(102, 143));
      3: v[30:23] = 8'($urandom_range(112, 114));
      4: v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      5: v[12:0] = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0FFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
  endtask

  task automatic write_mode(bit hdr);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= hdr;
    @(posedge clk);
    half_mode = hdr;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || pending_px_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Driver: a new word goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          (!pixel_q[0].hold || pending_px_q.size() == 0)) begin
        pixel_t p;
        p = pixel_q.pop_front();
        in_valid <= 1'b1;
        red_in <= p.r;
        green_in <= p.g;
        blue_in <= p.b;
        alpha_in <= p.a;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predicts accepted inputs and checks output words in order.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pixel_t p;
        p = '{r: red_in, g: green_in, b: blue_in, a: alpha_in, hold: 1'b0};
        pending_px_q.push_back(predict_pixel(p, half_mode));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (pending_px_q.size() == 0) begin
          report_mismatch("unexpected word", red_out, 16'h0);
        end else begin
          packed_px_t e;
          e = pending_px_q.pop_front();
          if (red_out !== e.r) report_mismatch("red", red_out, e.r);
          if (green_out !== e.g) report_mismatch("green", green_out, e.g);
          if (blue_out !== e.b) report_mismatch("blue", blue_out, e.b);
          if (alpha_out !== e.a) report_mismatch("alpha", alpha_out, e.a);
        end
      end
    end
  end

  initial begin
    logic [31:0] corner[20];
    pixel_t p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    alpha_in = '0;
    out_ready = 1'b0;
    half_mode = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 24;
    recv_stall_pct = 85;
    corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
               32'h3F80_0000, 32'h477F_E000, 32'h477F_F000, 32'h4780_0000,
               32'h3300_0000, 32'h3300_0001, 32'h3880_0000, 32'h3F80_1000,
               32'h3F80_3000, 32'h4B80_0000, 32'h437F_0000, 32'h3780_0000};
    build_gamma_lut();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int m = 0; m < 2; m++) begin
      write_mode(m[0]);
      for (int i = 0; i < 20; i++) begin
        p = '{r: corner[i], g: corner[(i + 5) % 20], b: corner[(i + 11) % 20],
              a: corner[(i + 17) % 20], hold: 1'b0};
        pixel_q.push_back(p);
      end
      wait_drained();
    end

    for (int c = 0; c < 6; c++) begin
      send_idle_pct = (c < 2) ? 24 : (c < 4) ? 85 : 0;
      recv_stall_pct = (c < 2) ? 85 : (c < 4) ? 24 : 0;
      write_mode(c[0]);
      for (int i = 0; i < CHUNK_SIZE; i++) begin
        p = '{r: random_float(), g: random_float(), b: random_float(),
              a: random_float(), hold: (c == 2 && i == 130)};
        pixel_q.push_back(p);
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hptm_pkg.sv
rtl/hptm_lane.sv
rtl/hdr_pixel_tone_map_pack_core.sv
tb/sv/tb_hdr_pixel_tone_map_pack_core.sv
